/* rtl/deque_with_value_search_defines.svh */
// Assertion macros for the deque with value search.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef DEQUE_WITH_VALUE_SEARCH_DEFINES_SVH
`define DEQUE_WITH_VALUE_SEARCH_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define DQVS_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// implication checked in the next cycle
`define DQVS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/dqvs_pkg.sv */
// Shared codes for the deque with value search.
// No dependencies.
`default_nettype none

package dqvs_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CONTAINS   = 3'd4,
    OP_REMOVE     = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned TOTAL_W = 9;
  localparam int unsigned OUT_W   = 32;

endpackage

`default_nettype wire

/* rtl/deque_with_value_search.sv */
// Bounded double-ended queue over a ring memory with membership test and remove-by-value.
// Depends on dqvs_pkg and deque_with_value_search_defines.svh.
//
// One request at a time; the result sits in an output register, so a new request is taken
// while the previous result waits. Pushes need no memory read; pops read the new front and
// back from the ring memory, one read each, unless the pop empties the ring; contains walks
// the entries from the front until a match or the end, and remove by value walks the ring
// as well. The walks use the single read port of the ring memory, one entry per cycle.
// Front and back values are cached in registers. No clearing pass after reset.
`default_nettype none

module deque_with_value_search #(
  parameter int unsigned CAPACITY    = 256,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic        [dqvs_pkg::OP_W-1:0]    operation_i,
  input  wire logic signed [31:0]                  item_value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic             [dqvs_pkg::STAT_W-1:0]  status_o,
  output logic                                     found_o,
  output logic             [dqvs_pkg::TOTAL_W-1:0] entry_total_o,
  output logic signed      [dqvs_pkg::OUT_W-1:0]   front_value_o,
  output logic signed      [dqvs_pkg::OUT_W-1:0]   back_value_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int unsigned OW = (VALUE_WIDTH < dqvs_pkg::OUT_W) ? VALUE_WIDTH
                                                                : dqvs_pkg::OUT_W;
  localparam int unsigned TW = (CW < dqvs_pkg::TOTAL_W) ? CW : dqvs_pkg::TOTAL_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_RD0   = 3'd3;
  localparam logic [2:0] S_RD1   = 3'd4;
  localparam logic [2:0] S_RD2   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]             state_q, state_d;
  logic [AW-1:0]          head_q, head_d;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          ridx_q, ridx_d;
  logic [CW-1:0]          cidx_q, cidx_d;
  logic                   cval_q, cval_d;
  logic [dqvs_pkg::OP_W-1:0]   op_q, op_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [VALUE_WIDTH-1:0] front_q, front_d;
  logic [VALUE_WIDTH-1:0] back_q, back_d;
  logic [dqvs_pkg::STAT_W-1:0] status_q, status_d;
  logic                   found_q, found_d;

  logic                          out_valid_q, out_valid_d;
  logic [dqvs_pkg::STAT_W-1:0]   out_status_q, out_status_d;
  logic                          out_found_q, out_found_d;
  logic [dqvs_pkg::TOTAL_W-1:0]  out_total_q, out_total_d;
  logic [dqvs_pkg::OUT_W-1:0]    out_front_q, out_front_d;
  logic [dqvs_pkg::OUT_W-1:0]    out_back_q, out_back_d;

  logic [VALUE_WIDTH-1:0] mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] rdata_q;
  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;

  logic [VALUE_WIDTH-1:0] vin;
  logic                   full, empty;

  assign vin   = VALUE_WIDTH'(item_value_i[IW-1:0]);
  assign full  = (count_q == CW'(CAPACITY));
  assign empty = (count_q == '0);

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_o       = out_found_q;
  assign entry_total_o = out_total_q;
  assign front_value_o = out_front_q;
  assign back_value_o  = out_back_q;

  function automatic logic [AW-1:0] ring_at(input logic [AW-1:0] off);
    logic [AW:0] p;
    p = {1'b0, head_q} + {1'b0, off};
    if (p >= (AW+1)'(CAPACITY)) begin
      p = p - (AW+1)'(CAPACITY);
    end
    return p[AW-1:0];
  endfunction

  always_comb begin
    logic [AW-1:0] hp;
    logic [CW-1:0] last;
    hp           = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - 1'b1;
    last         = count_q - CW'(1);
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    ridx_d       = ridx_q;
    cidx_d       = cidx_q;
    cval_d       = cval_q;
    op_d         = op_q;
    val_d        = val_q;
    front_d      = front_q;
    back_d       = back_q;
    status_d     = status_q;
    found_d      = found_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = val_q;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_total_d  = out_total_q;
    out_front_d  = out_front_q;
    out_back_d   = out_back_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = operation_i;
          val_d    = vin;
          status_d = dqvs_pkg::ST_DONE;
          found_d  = 1'b0;
          ridx_d   = '0;
          cidx_d   = '0;
          cval_d   = 1'b0;
          state_d  = S_FIN;
          case (operation_i)
            dqvs_pkg::OP_PUSH_FRONT: begin
              if (full) begin
                status_d = dqvs_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = hp;
                mem_wdata = vin;
                head_d    = hp;
                count_d   = count_q + CW'(1);
                front_d   = vin;
                if (empty) begin
                  back_d = vin;
                end
              end
            end
            dqvs_pkg::OP_PUSH_BACK: begin
              if (full) begin
                status_d = dqvs_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = ring_at(count_q[AW-1:0]);
                mem_wdata = vin;
                count_d   = count_q + CW'(1);
                back_d    = vin;
                if (empty) begin
                  front_d = vin;
                end
              end
            end
            dqvs_pkg::OP_POP_FRONT: begin
              if (empty) begin
                status_d = dqvs_pkg::ST_EMPTY;
              end else begin
                head_d  = ring_at(AW'(1));
                count_d = last;
                if (last != '0) begin
                  state_d = S_RD0;
                end
              end
            end
            dqvs_pkg::OP_POP_BACK: begin
              if (empty) begin
                status_d = dqvs_pkg::ST_EMPTY;
              end else begin
                count_d = last;
                if (last != '0) begin
                  state_d = S_RD0;
                end
              end
            end
            dqvs_pkg::OP_CONTAINS: begin
              if (!empty) begin
                state_d = S_SCAN;
              end
            end
            dqvs_pkg::OP_REMOVE: begin
              if (empty) begin
                status_d = dqvs_pkg::ST_EMPTY;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (cval_q && rdata_q == val_q) begin
          found_d = 1'b1;
          if (op_q == dqvs_pkg::OP_REMOVE) begin
            state_d = S_SHIFT;
            ridx_d  = cidx_q + CW'(1);
            cval_d  = 1'b0;
          end else begin
            state_d = S_FIN;
          end
        end else if (cval_q && cidx_q == last) begin
          state_d = S_FIN;
        end else begin
          cval_d = (ridx_q < count_q);
          if (ridx_q < count_q) begin
            mem_re    = 1'b1;
            mem_raddr = ring_at(ridx_q[AW-1:0]);
            cidx_d    = ridx_q;
            ridx_d    = ridx_q + CW'(1);
          end
        end
      end
      S_SHIFT: begin
        // cidx_q is the write offset, ridx_q the read offset ahead of it
        if (cval_q) begin
          mem_we    = 1'b1;
          mem_waddr = ring_at(cidx_q[AW-1:0]);
          mem_wdata = rdata_q;
          cidx_d    = cidx_q + CW'(1);
        end
        if (ridx_q < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = ring_at(ridx_q[AW-1:0]);
          ridx_d    = ridx_q + CW'(1);
          cval_d    = 1'b1;
        end else begin
          cval_d = 1'b0;
          if (!cval_q) begin
            count_d = last;
            state_d = (last == '0) ? S_FIN : S_RD0;
          end
        end
      end
      S_RD0: begin
        mem_re    = 1'b1;
        mem_raddr = ring_at('0);
        state_d   = S_RD1;
      end
      S_RD1: begin
        front_d   = rdata_q;
        mem_re    = 1'b1;
        mem_raddr = ring_at(last[AW-1:0]);
        state_d   = S_RD2;
      end
      S_RD2: begin
        back_d  = rdata_q;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_found_d  = found_q;
          out_total_d  = dqvs_pkg::TOTAL_W'(count_q[TW-1:0]);
          out_front_d  = empty ? '0 : dqvs_pkg::OUT_W'(front_q[OW-1:0]);
          out_back_d   = empty ? '0 : dqvs_pkg::OUT_W'(back_q[OW-1:0]);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      ridx_q      <= '0;
      cidx_q      <= '0;
      cval_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      ridx_q      <= ridx_d;
      cidx_q      <= cidx_d;
      cval_q      <= cval_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    val_q        <= val_d;
    front_q      <= front_d;
    back_q       <= back_d;
    status_q     <= status_d;
    found_q      <= found_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
    out_total_q  <= out_total_d;
    out_front_q  <= out_front_d;
    out_back_q   <= out_back_d;
  end

`include "deque_with_value_search_defines.svh"

  `DQVS_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(CAPACITY), "count above capacity")
  `DQVS_ASSERT_NEXT(a_accept_busy, in_valid_i && !in_stall_o, state_q != S_IDLE,
                    "request accepted but block still idle")
  `DQVS_ASSERT_IMP(a_found_done, out_valid_o && found_o, status_o == dqvs_pkg::ST_DONE,
                   "match reported with reject status")
  `DQVS_ASSERT_IMP(a_port_clash, mem_we && mem_re, mem_waddr != mem_raddr,
                   "ring read and write hit the same entry")

endmodule

`default_nettype wire

/* bench/deque_with_value_search_test.sv */
// Self-checking testbench for deque_with_value_search: directed edge cases, a full ring
// under output back-pressure, and random request mixes checked against a queue-based model.
// Depends on dqvs_pkg and the deque_with_value_search RTL.
`timescale 1ns / 1ps

module deque_with_value_search_test;

  localparam int unsigned DEPTH          = 256;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned DRAIN_CYCLES   = 300;

  // operation codes with no defined action
  localparam bit [2:0] OP_SPARE_6 = 3'd6;
  localparam bit [2:0] OP_SPARE_7 = 3'd7;

  typedef struct {
    logic [1:0]  status;
    logic        found;
    logic [8:0]  total;
    logic [31:0] front;
    logic [31:0] back;
  } deque_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         operation_i;
  logic signed [31:0] item_value_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic               found_o;
  logic [8:0]         entry_total_o;
  logic signed [31:0] front_value_o;
  logic signed [31:0] back_value_o;

  logic [31:0]   deque_model[$];
  deque_result_t expected_results[$];
  int            error_count  = 0;
  int            quiet_cycles = 0;
  bit            sender_idle_on;
  bit            recv_idle_on;
  bit            long_hold_request;
  bit            long_hold_done = 1'b0;

  deque_with_value_search #(
    .CAPACITY    (DEPTH),
    .VALUE_WIDTH (32)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .item_value_i  (item_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .found_o       (found_o),
    .entry_total_o (entry_total_o),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic deque_result_t apply_deque_op(bit [2:0] op, logic [31:0] value);
    deque_result_t res;
    int hit;
    res.status = dqvs_pkg::ST_DONE;
    res.found  = 1'b0;
    hit        = -1;
    case (op)
      dqvs_pkg::OP_PUSH_FRONT: begin
        if (deque_model.size() >= DEPTH) res.status = dqvs_pkg::ST_FULL;
        else deque_model.push_front(value);
      end
      dqvs_pkg::OP_PUSH_BACK: begin
        if (deque_model.size() >= DEPTH) res.status = dqvs_pkg::ST_FULL;
        else deque_model.push_back(value);
      end
      dqvs_pkg::OP_POP_FRONT: begin
        if (deque_model.size() == 0) res.status = dqvs_pkg::ST_EMPTY;
        else void'(deque_model.pop_front());
      end
      dqvs_pkg::OP_POP_BACK: begin
        if (deque_model.size() == 0) res.status = dqvs_pkg::ST_EMPTY;
        else void'(deque_model.pop_back());
      end
      dqvs_pkg::OP_CONTAINS, dqvs_pkg::OP_REMOVE: begin
        for (int i = 0; i < deque_model.size() && hit < 0; i++)
          if (deque_model[i] == value) hit = i;
        if (op == dqvs_pkg::OP_REMOVE && deque_model.size() == 0)
          res.status = dqvs_pkg::ST_EMPTY;
        res.found = (hit >= 0);
        if (op == dqvs_pkg::OP_REMOVE && hit >= 0) deque_model.delete(hit);
      end
      default: ;
    endcase
    res.total = 9'(deque_model.size());
    res.front = (deque_model.size() != 0) ? deque_model[0] : 32'd0;
    res.back  = (deque_model.size() != 0) ? deque_model[deque_model.size() - 1] : 32'd0;
    return res;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(bit [2:0] op, logic [31:0] value);
    if (sender_idle_on && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    item_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(apply_deque_op(op, value));
    @(negedge clk_i);
  endtask

  // mostly values already held or from a small pool, so searches hit and duplicates occur
  function automatic logic [31:0] pick_value();
    int choice;
    choice = $urandom_range(0, 9);
    if (choice < 4 && deque_model.size() != 0)
      return deque_model[$urandom_range(0, deque_model.size() - 1)];
    if (choice < 7) return $urandom_range(0, 15);
    if (choice == 7) return -$urandom_range(1, 8);
    return $urandom();
  endfunction

  function automatic bit [2:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (deque_model.size() > 48 && r < 36) r = r + 36;
    if (r < 18) return dqvs_pkg::OP_PUSH_FRONT;
    if (r < 36) return dqvs_pkg::OP_PUSH_BACK;
    if (r < 48) return dqvs_pkg::OP_POP_FRONT;
    if (r < 60) return dqvs_pkg::OP_POP_BACK;
    if (r < 76) return dqvs_pkg::OP_CONTAINS;
    if (r < 96) return dqvs_pkg::OP_REMOVE;
    if (r < 98) return OP_SPARE_6;
    return OP_SPARE_7;
  endfunction

  task automatic test_edge_cases();
    send_request(dqvs_pkg::OP_POP_FRONT, 32'd0);
    send_request(dqvs_pkg::OP_POP_BACK, 32'hFFFF_FFFF);
    send_request(dqvs_pkg::OP_REMOVE, 32'd3);
    send_request(dqvs_pkg::OP_CONTAINS, 32'd3);
    send_request(OP_SPARE_6, 32'd1);
    send_request(OP_SPARE_7, 32'd2);
    send_request(dqvs_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF);
    send_request(dqvs_pkg::OP_PUSH_FRONT, 32'h8000_0000);
    send_request(dqvs_pkg::OP_PUSH_BACK, 32'd0);
    send_request(dqvs_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_request(dqvs_pkg::OP_PUSH_BACK, 32'd5);
    send_request(dqvs_pkg::OP_PUSH_BACK, 32'd0);
    send_request(dqvs_pkg::OP_CONTAINS, 32'd0);
    send_request(dqvs_pkg::OP_CONTAINS, 32'd12345);
    send_request(OP_SPARE_6, 32'hA5A5_A5A5);
    send_request(OP_SPARE_7, 32'h5A5A_5A5A);
    send_request(dqvs_pkg::OP_REMOVE, 32'h8000_0000);
    send_request(dqvs_pkg::OP_REMOVE, 32'd0);
    send_request(dqvs_pkg::OP_REMOVE, 32'd0);
    send_request(dqvs_pkg::OP_REMOVE, 32'd99);
    send_request(dqvs_pkg::OP_REMOVE, 32'hFFFF_FFFF);
    send_request(dqvs_pkg::OP_POP_FRONT, 32'd0);
    send_request(dqvs_pkg::OP_POP_BACK, 32'd0);
    send_request(dqvs_pkg::OP_PUSH_FRONT, 32'd1);
    send_request(dqvs_pkg::OP_REMOVE, 32'd1);
  endtask

  // hold the output off once at the start, then fill, probe the full ring and drain
  task automatic test_full_ring();
    long_hold_request = 1'b1;
    while (deque_model.size() < DEPTH)
      send_request($urandom_range(0, 1) ? dqvs_pkg::OP_PUSH_FRONT : dqvs_pkg::OP_PUSH_BACK,
                   $urandom());
    send_request(dqvs_pkg::OP_PUSH_FRONT, $urandom());
    send_request(dqvs_pkg::OP_PUSH_BACK, $urandom());
    send_request(dqvs_pkg::OP_CONTAINS, deque_model[DEPTH - 1]);
    send_request(dqvs_pkg::OP_CONTAINS, $urandom());
    send_request(dqvs_pkg::OP_REMOVE, deque_model[DEPTH - 1]);
    send_request(dqvs_pkg::OP_PUSH_BACK, $urandom());
    send_request(dqvs_pkg::OP_REMOVE, deque_model[0]);
    send_request(dqvs_pkg::OP_REMOVE, deque_model[DEPTH / 2]);
    send_request(dqvs_pkg::OP_REMOVE, $urandom());
    while (deque_model.size() != 0)
      send_request($urandom_range(0, 1) ? dqvs_pkg::OP_POP_FRONT : dqvs_pkg::OP_POP_BACK,
                   $urandom());
    send_request(dqvs_pkg::OP_POP_BACK, $urandom());
  endtask

  task automatic test_random_mix(int count);
    repeat (count) send_request(pick_op(), pick_value());
  endtask

  task automatic test_back_to_back(int count);
    sender_idle_on = 1'b0;
    recv_idle_on   = 1'b0;
    test_random_mix(count);
  endtask

  always begin
    @(negedge clk_i);
    if (long_hold_request && !long_hold_done) begin
      long_hold_done = 1'b1;
      out_stall_i <= 1'b1;
      repeat (LONG_HOLD) @(negedge clk_i);
      out_stall_i <= 1'b0;
    end else if (recv_idle_on && $urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_results
    deque_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding");
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          error_count++;
        end
        if (found_o !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found_o);
          error_count++;
        end
        if (entry_total_o !== want.total) begin
          $error("entry_total: expected %0d, got %0d", want.total, entry_total_o);
          error_count++;
        end
        if (front_value_o !== want.front) begin
          $error("front_value: expected %h, got %h", want.front, front_value_o);
          error_count++;
        end
        if (back_value_o !== want.back) begin
          $error("back_value: expected %h, got %h", want.back, back_value_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    operation_i       = '0;
    item_value_i      = '0;
    sender_idle_on    = 1'b1;
    recv_idle_on      = 1'b1;
    long_hold_request = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_edge_cases();
    test_full_ring();
    test_random_mix(350);
    test_back_to_back(150);

    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

/* deque_with_value_search.f */
+incdir+rtl
rtl/dqvs_pkg.sv
rtl/deque_with_value_search.sv
bench/deque_with_value_search_test.sv
